>>> sv/tlbf_pkg.sv
// Shared types and constants for the translation buffer.
package tlbf_pkg;

  localparam int PID_W   = 16;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 20;
  localparam int SLOT_W  = 5;
  localparam int STAMP_W = 32;
  localparam int SIZE_W  = 6;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // Register index taken from paddr[2].
  localparam logic REG_LRU_MODE       = 1'b0;
  localparam logic REG_ENTRIES_IN_USE = 1'b1;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } bk_state_e;

  typedef struct packed {
    op_e                op;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

endpackage

>>> sv/tlbf_front.sv
// Front end: accepts request transactions, classifies them and queues them for the back end.
module tlbf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [tlbf_pkg::PID_W-1:0]   pid_i,
  input  logic [tlbf_pkg::PAGE_W-1:0]  page_i,
  input  logic [tlbf_pkg::FRAME_W-1:0] frame_i,
  output logic                         cmd_valid_o,
  output tlbf_pkg::cmd_t               cmd_o,
  input  logic                         cmd_ready_i
);
  import tlbf_pkg::*;

  cmd_t       q_mem [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] level_q, level_d;
  logic       push, pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.op    = op_e'(kind_i);
    cmd_new.pid   = pid_i;
    cmd_new.page  = page_i;
    cmd_new.frame = frame_i;
  end

  assign in_ready_o  = (level_q != 2'd2);
  assign cmd_valid_o = (level_q != 2'd0);
  assign cmd_o       = q_mem[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = pop ? ~rptr_q : rptr_q;
    level_d = level_q;
    if (push && !pop) begin
      level_d = level_q + 2'd1;
    end else if (pop && !push) begin
      level_d = level_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      level_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= cmd_new;
    end
  end

endmodule

>>> sv/tlbf_back.sv
// Back end: entry store, parallel lookup, append/shift/LRU-scan fill and result register.
module tlbf_back #(
  parameter int ENTRIES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  tlbf_pkg::cmd_t               cmd_i,
  output logic                         cmd_ready_o,
  input  logic                         lru_mode_i,
  input  logic [tlbf_pkg::SIZE_W-1:0]  entries_in_use_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [tlbf_pkg::FRAME_W-1:0] frame_o,
  output logic [tlbf_pkg::SLOT_W-1:0]  slot_o
);
  import tlbf_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [PID_W-1:0]   pid_q   [ENTRIES];
  logic [PAGE_W-1:0]  page_q  [ENTRIES];
  logic [FRAME_W-1:0] frame_q [ENTRIES];
  logic [STAMP_W-1:0] stamp_q [ENTRIES];

  logic [CW-1:0]      count_q;
  logic [STAMP_W-1:0] clock_q;
  bk_state_e          state_q, state_d;
  cmd_t               cmd_q;
  logic [CW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      vict_q, vict_d;
  logic [STAMP_W-1:0] min_q, min_d;

  logic               out_valid_q;
  logic               out_hit_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [SLOT_W-1:0]  out_slot_q;

  logic [SIZE_W:0]    size_ext;
  logic [SIZE_W:0]    size_lim;
  logic [CW-1:0]      eff_size;
  logic               hit;
  logic [IW-1:0]      hit_idx;
  logic [STAMP_W-1:0] scan_stamp;
  logic               out_free;

  logic               cmd_ld;
  logic               wr_en;
  logic [IW-1:0]      wr_slot;
  cmd_t               wr_cmd;
  logic               shift_en;
  logic               stamp_en;
  logic [IW-1:0]      stamp_slot;
  logic               count_inc;
  logic               out_load;
  logic               res_hit;
  logic [FRAME_W-1:0] res_frame;
  logic [IW-1:0]      res_slot;

  always_comb begin
    size_ext = {1'b0, entries_in_use_i};
    if (entries_in_use_i == '0) begin
      size_lim = (SIZE_W+1)'(1);
    end else if (size_ext > (SIZE_W+1)'(ENTRIES)) begin
      size_lim = (SIZE_W+1)'(ENTRIES);
    end else begin
      size_lim = size_ext;
    end
    eff_size = CW'(size_lim);
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if ((CW'(i) < count_q) && (pid_q[i] == cmd_i.pid) && (page_q[i] == cmd_i.page)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  assign scan_stamp = stamp_q[idx_q[IW-1:0]];
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    vict_d      = vict_q;
    min_d       = min_q;
    cmd_ready_o = 1'b0;
    cmd_ld      = 1'b0;
    wr_en       = 1'b0;
    wr_slot     = '0;
    wr_cmd      = cmd_i;
    shift_en    = 1'b0;
    stamp_en    = 1'b0;
    stamp_slot  = '0;
    count_inc   = 1'b0;
    out_load    = 1'b0;
    res_hit     = 1'b0;
    res_frame   = '0;
    res_slot    = '0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          if (cmd_i.op == OP_LOOKUP) begin
            out_load = 1'b1;
            if (hit) begin
              stamp_en   = 1'b1;
              stamp_slot = hit_idx;
              res_hit    = 1'b1;
              res_frame  = frame_q[hit_idx];
              res_slot   = hit_idx;
            end
          end else if (count_q < eff_size) begin
            wr_en      = 1'b1;
            wr_slot    = count_q[IW-1:0];
            stamp_en   = 1'b1;
            stamp_slot = count_q[IW-1:0];
            count_inc  = 1'b1;
            out_load   = 1'b1;
            res_slot   = count_q[IW-1:0];
          end else if (!lru_mode_i) begin
            shift_en   = 1'b1;
            wr_en      = 1'b1;
            wr_slot    = IW'(count_q - CW'(1));
            stamp_en   = 1'b1;
            stamp_slot = IW'(count_q - CW'(1));
            out_load   = 1'b1;
            res_slot   = IW'(count_q - CW'(1));
          end else begin
            cmd_ld  = 1'b1;
            vict_d  = '0;
            min_d   = stamp_q[0];
            idx_d   = CW'(1);
            state_d = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        wr_cmd = cmd_q;
        if (idx_q < count_q) begin
          if (scan_stamp < min_q) begin
            min_d  = scan_stamp;
            vict_d = idx_q[IW-1:0];
          end
          idx_d = idx_q + CW'(1);
        end else if (out_free) begin
          wr_en      = 1'b1;
          wr_slot    = vict_q;
          stamp_en   = 1'b1;
          stamp_slot = vict_q;
          out_load   = 1'b1;
          res_slot   = vict_q;
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (count_inc) begin
        count_q <= count_q + CW'(1);
      end
      if (stamp_en) begin
        clock_q <= clock_q + STAMP_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    vict_q <= vict_d;
    min_q  <= min_d;
    if (cmd_ld) begin
      cmd_q <= cmd_i;
    end
    if (out_load) begin
      out_hit_q   <= res_hit;
      out_frame_q <= res_frame;
      out_slot_q  <= SLOT_W'(res_slot);
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if ((CW'(i) + CW'(1)) < count_q) begin
          pid_q[i]   <= pid_q[i+1];
          page_q[i]  <= page_q[i+1];
          frame_q[i] <= frame_q[i+1];
          stamp_q[i] <= stamp_q[i+1];
        end
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_en && (wr_slot == IW'(i))) begin
        pid_q[i]   <= wr_cmd.pid;
        page_q[i]  <= wr_cmd.page;
        frame_q[i] <= wr_cmd.frame;
      end
      if (stamp_en && (stamp_slot == IW'(i))) begin
        stamp_q[i] <= clock_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign frame_o     = out_frame_q;
  assign slot_o      = out_slot_q;

endmodule

>>> sv/tlb_fifo_lru_lookup_fill.sv
// Top level of the fully associative translation buffer with FIFO or LRU replacement.
//
// Requests arrive on the s_axis channel: tuser is the kind (0 lookup, 1 fill), tdata
// carries process id, page number and the frame to store. Each request gives exactly
// one result on the m_axis channel: hit, frame and slot.
// A two-deep request queue sits in front of the execution unit, and the result sits
// in an output register, so up to two more requests are taken while the receiver holds
// tready low; s_axis_tready drops whenever the request queue is full.
// Lookups, appending fills and FIFO replacements pass through the request queue and the
// output register and sustain one transaction per cycle while the receiver does not stall
// the output. An LRU replacement walks the stamps of the filled slots one per cycle in the
// execution unit, taking no new request until it has written the victim slot.
// Configuration goes through the APB port: lru_mode at address 0, entries_in_use at
// address 4; write only while the block is idle.
// Reset empties the buffer, clears the use clock and sets lru_mode to 0 and
// entries_in_use to 32; no clearing pass is needed.
module tlb_fifo_lru_lookup_fill #(
  parameter int ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // process_id, page_number, frame_in
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // hit, frame_out, slot_used, zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlbf_pkg::*;

  logic               lru_mode_q;
  logic [SIZE_W-1:0]  size_q;
  logic               cfg_wr;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;
  logic               hit;
  logic [FRAME_W-1:0] frame_out;
  logic [SLOT_W-1:0]  slot_used;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lru_mode_q <= 1'b0;
      size_q     <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LRU_MODE:       lru_mode_q <= pwdata[0];
        REG_ENTRIES_IN_USE: size_q     <= pwdata[SIZE_W-1:0];
        default:            lru_mode_q <= lru_mode_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LRU_MODE:       prdata = {31'd0, lru_mode_q};
      REG_ENTRIES_IN_USE: prdata = {{(32-SIZE_W){1'b0}}, size_q};
      default:            prdata = '0;
    endcase
  end

  tlbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .pid_i       (s_axis_tdata[15:0]),
    .page_i      (s_axis_tdata[35:16]),
    .frame_i     (s_axis_tdata[55:36]),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  tlbf_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_ready_o      (cmd_ready),
    .lru_mode_i       (lru_mode_q),
    .entries_in_use_i (size_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .hit_o            (hit),
    .frame_o          (frame_out),
    .slot_o           (slot_used)
  );

  assign m_axis_tdata = {6'd0, slot_used, frame_out, hit};

endmodule
